>>> rtl/core/pbw_pkg.sv
package pbw_pkg;

    localparam int DEF_SRC_MAX_WIDTH  = 512;
    localparam int DEF_SRC_MAX_HEIGHT = 512;
    localparam int DEF_CHANNELS       = 3;
    localparam int DEF_DST_COORD_BITS = 12;

    localparam int CH_W        = 8;
    localparam int COEF_W      = 32;
    localparam int FRAC        = 16;
    localparam int W_W         = FRAC + 1;
    localparam int QSCALE      = 32;
    localparam int OFS_SHIFT   = 12;
    localparam int WOFS_SHIFT  = 16;
    localparam int SIZE_W      = 13;
    localparam int SIZE_CFG_W  = 10;
    localparam int MIN_SIZE    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int BANKS       = 4;

    localparam logic [W_W-1:0] ONE_W = W_W'(1) << FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X      = 3'd0,
        REG_ROW_Y      = 3'd1,
        REG_ROW_W      = 3'd2,
        REG_OFFSETS    = 3'd3,
        REG_W_OFFSET   = 3'd4,
        REG_SRC_WIDTH  = 3'd5,
        REG_SRC_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        KIND_WRITE   = 1'b0,
        KIND_REQUEST = 1'b1
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctl_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h22;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
    } coef_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Quotient bits: 16 fraction bits plus enough integer bits for the largest size.
    function automatic int quot_bits(input int w, input int h);
        return FRAC + $clog2(max2(w, h));
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] v,
                                                      input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] s;
        s = SIZE_W'(v);
        if (s < SIZE_W'(MIN_SIZE)) s = SIZE_W'(MIN_SIZE);
        if (s > maxv) s = maxv;
        return s;
    endfunction

endpackage

>>> rtl/core/pbw_ram.sv
module pbw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/pbw_front.sv
module pbw_front #(
    parameter int SRC_MAX_WIDTH  = 512,
    parameter int SRC_MAX_HEIGHT = 512,
    parameter int CHANNELS       = 3,
    parameter int DST_COORD_BITS = 12
) (
    input  logic                                 start,
    input  logic                                 kind,
    input  logic [DST_COORD_BITS-1:0]            coord_x,
    input  logic [DST_COORD_BITS-1:0]            coord_y,
    input  logic [pbw_pkg::CH_W*CHANNELS-1:0]    pixel_in,
    input  logic                                 full,
    output logic                                 busy,
    output logic                                 push,
    output logic [2*DST_COORD_BITS+pbw_pkg::CH_W*CHANNELS:0] entry
);
    import pbw_pkg::*;

    logic in_store;

    // Drop pixel writes that fall outside the store.
    assign in_store = (32'(coord_x) < 32'(SRC_MAX_WIDTH)) && (32'(coord_y) < 32'(SRC_MAX_HEIGHT));
    assign busy     = full;
    assign push     = start && !full && ((kind_t'(kind) == KIND_REQUEST) || in_store);
    assign entry    = {kind, coord_x, coord_y, pixel_in};

endmodule

>>> rtl/core/pbw_queue.sv
module pbw_queue #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);
    import pbw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // The back end never stalls: pop whenever something is held.
    assign pop       = (count_reg != '0);
    assign out_valid = pop;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count lost an item");

endmodule

>>> rtl/core/pbw_map.sv
module pbw_map #(
    parameter int SRC_MAX_WIDTH  = 512,
    parameter int SRC_MAX_HEIGHT = 512,
    parameter int CHANNELS       = 3,
    parameter int DST_COORD_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [2*DST_COORD_BITS+pbw_pkg::CH_W*CHANNELS:0] in_data,
    input  pbw_pkg::coef_t           coef,
    output pbw_pkg::ctl_t            out_ctl,
    output logic                     out_ok,
    output logic [pbw_pkg::quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT)-1:0] out_qx,
    output logic [pbw_pkg::quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT)-1:0] out_qy,
    output logic [2*DST_COORD_BITS+pbw_pkg::CH_W*CHANNELS-1:0] out_pay
);
    import pbw_pkg::*;

    localparam int DCB    = DST_COORD_BITS;
    localparam int PIX_W  = CH_W * CHANNELS;
    localparam int PAY_W  = 2 * DCB + PIX_W;
    localparam int PROD_W = COEF_W + DCB + 1;
    localparam int NUM_W  = max2(PROD_W, COEF_W + OFS_SHIFT) + 2;
    localparam int DEN_W  = max2(PROD_W, COEF_W + WOFS_SHIFT) + 2;
    localparam int QB     = quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT);
    localparam int PRE_SH = QSCALE - QB;
    localparam int CMP_W  = max2(NUM_W + PRE_SH, DEN_W);

    logic [DCB-1:0]          in_x, in_y;
    logic signed [DCB:0]     xs, ys;

    ctl_t                    ctl1_reg, ctl2_reg;
    logic [PAY_W-1:0]        pay1_reg, pay2_reg;
    logic signed [PROD_W-1:0] px0_reg, px1_reg, py0_reg, py1_reg, pw0_reg, pw1_reg;
    logic signed [NUM_W-1:0] nx2_reg, ny2_reg;
    logic signed [DEN_W-1:0] dd2_reg;

    logic [CMP_W-1:0]        shx, shy, den_c;
    logic                    ok2;

    ctl_t                    ctl_reg [0:QB];
    logic                    ok_reg  [0:QB];
    logic [PAY_W-1:0]        pay_reg [0:QB];
    logic [DEN_W-1:0]        den_reg [0:QB];
    logic [DEN_W-1:0]        rx_reg  [0:QB];
    logic [DEN_W-1:0]        ry_reg  [0:QB];
    logic [QB-1:0]           qx_reg  [0:QB];
    logic [QB-1:0]           qy_reg  [0:QB];

    logic [DEN_W-1:0]        tx [0:QB-1];
    logic [DEN_W-1:0]        ty [0:QB-1];
    logic                    gx [0:QB-1];
    logic                    gy [0:QB-1];

    assign in_x = in_data[PAY_W-1 -: DCB];
    assign in_y = in_data[PAY_W-DCB-1 -: DCB];
    assign xs   = signed'({1'b0, in_x});
    assign ys   = signed'({1'b0, in_y});

    // Outside when the denominator is not positive, a numerator is negative,
    // or the quotient would reach past the largest source size.
    always_comb
    begin
        shx   = CMP_W'(nx2_reg) << PRE_SH;
        shy   = CMP_W'(ny2_reg) << PRE_SH;
        den_c = CMP_W'(dd2_reg);
        ok2   = !dd2_reg[DEN_W-1] && (dd2_reg != '0) && !nx2_reg[NUM_W-1]
                && !ny2_reg[NUM_W-1] && (shx < den_c) && (shy < den_c);
    end

    // One restoring step per stage on each axis.
    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            tx[k] = {rx_reg[k][DEN_W-2:0], 1'b0};
            ty[k] = {ry_reg[k][DEN_W-2:0], 1'b0};
            gx[k] = (tx[k] >= den_reg[k]);
            gy[k] = (ty[k] >= den_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            for (int k = 0; k <= QB; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.kind  <= kind_t'(in_data[PAY_W]);
            ctl2_reg       <= ctl1_reg;
            ctl_reg[0]     <= ctl2_reg;
            for (int k = 0; k < QB; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pay1_reg <= in_data[PAY_W-1:0];
        px0_reg  <= coef.h00 * xs;
        px1_reg  <= coef.h01 * ys;
        py0_reg  <= coef.h10 * xs;
        py1_reg  <= coef.h11 * ys;
        pw0_reg  <= coef.h20 * xs;
        pw1_reg  <= coef.h21 * ys;

        pay2_reg <= pay1_reg;
        nx2_reg  <= NUM_W'(px0_reg) + NUM_W'(px1_reg) + (NUM_W'(coef.h02) <<< OFS_SHIFT);
        ny2_reg  <= NUM_W'(py0_reg) + NUM_W'(py1_reg) + (NUM_W'(coef.h12) <<< OFS_SHIFT);
        dd2_reg  <= DEN_W'(pw0_reg) + DEN_W'(pw1_reg) + (DEN_W'(coef.h22) <<< WOFS_SHIFT);

        pay_reg[0] <= pay2_reg;
        ok_reg[0]  <= ok2;
        den_reg[0] <= dd2_reg;
        rx_reg[0]  <= shx[DEN_W-1:0];
        ry_reg[0]  <= shy[DEN_W-1:0];
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;

        for (int k = 0; k < QB; k++)
        begin
            pay_reg[k+1] <= pay_reg[k];
            ok_reg[k+1]  <= ok_reg[k];
            den_reg[k+1] <= den_reg[k];
            rx_reg[k+1]  <= gx[k] ? (tx[k] - den_reg[k]) : tx[k];
            ry_reg[k+1]  <= gy[k] ? (ty[k] - den_reg[k]) : ty[k];
            qx_reg[k+1]  <= {qx_reg[k][QB-2:0], gx[k]};
            qy_reg[k+1]  <= {qy_reg[k][QB-2:0], gy[k]};
        end
    end

    assign out_ctl = ctl_reg[QB];
    assign out_ok  = ok_reg[QB];
    assign out_qx  = qx_reg[QB];
    assign out_qy  = qy_reg[QB];
    assign out_pay = pay_reg[QB];

endmodule

>>> rtl/core/pbw_sample.sv
module pbw_sample #(
    parameter int SRC_MAX_WIDTH  = 512,
    parameter int SRC_MAX_HEIGHT = 512,
    parameter int CHANNELS       = 3,
    parameter int DST_COORD_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pbw_pkg::ctl_t            in_ctl,
    input  logic                     in_ok,
    input  logic [pbw_pkg::quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT)-1:0] in_qx,
    input  logic [pbw_pkg::quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT)-1:0] in_qy,
    input  logic [2*DST_COORD_BITS+pbw_pkg::CH_W*CHANNELS-1:0] in_pay,
    input  logic [pbw_pkg::SIZE_W-1:0] width,
    input  logic [pbw_pkg::SIZE_W-1:0] height,
    output logic                     done,
    output logic [pbw_pkg::CH_W*CHANNELS-1:0] pixel_out,
    output logic                     inside_res
);
    import pbw_pkg::*;

    localparam int DCB   = DST_COORD_BITS;
    localparam int PIX_W = CH_W * CHANNELS;
    localparam int PAY_W = 2 * DCB + PIX_W;
    localparam int QB    = quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT);
    localparam int BX_W  = $clog2(SRC_MAX_WIDTH);
    localparam int BY_W  = $clog2(SRC_MAX_HEIGHT);
    localparam int WB    = (SRC_MAX_WIDTH + 1) / 2;
    localparam int HB    = (SRC_MAX_HEIGHT + 1) / 2;
    localparam int DEPTH = WB * HB;
    localparam int AW    = $clog2(DEPTH);
    localparam int WP_W  = 2 * W_W;
    localparam int ACC_W = CH_W + WP_W;

    logic [QB-FRAC-1:0] ipx, ipy;
    logic [FRAC-1:0]    frx, fry;
    logic               inx, iny;
    logic [BX_W-1:0]    bx_c;
    logic [BY_W-1:0]    by_c;
    logic [W_W-1:0]     fx_c, fy_c;
    logic [BX_W+DCB-1:0] cx_ext;
    logic [BY_W+DCB-1:0] cy_ext;

    ctl_t               ctl1_reg, ctl2_reg, ctl3_reg;
    logic               in1_reg, in2_reg, in3_reg;
    logic [BX_W-1:0]    bx1_reg, wcol1_reg;
    logic [BY_W-1:0]    by1_reg, wrow1_reg;
    logic [W_W-1:0]     fx1_reg, fy1_reg;
    logic [PIX_W-1:0]   wpix1_reg;

    logic               bx0_reg, by0_reg;
    logic [WP_W-1:0]    w00_reg, w01_reg, w10_reg, w11_reg;
    logic [W_W-1:0]     nxw, nyw;

    logic [BANKS-1:0][PIX_W-1:0] rdata;
    logic [ACC_W-1:0]   prod_reg [0:CHANNELS-1][0:3];
    logic [CH_W-1:0]    p_c [0:CHANNELS-1][0:3];
    logic [ACC_W-1:0]   acc [0:CHANNELS-1];
    logic [PIX_W-1:0]   pix_c;

    logic               done_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               inside_reg;

    assign ipx    = in_qx[QB-1:FRAC];
    assign frx    = in_qx[FRAC-1:0];
    assign ipy    = in_qy[QB-1:FRAC];
    assign fry    = in_qy[FRAC-1:0];
    assign cx_ext = {{BX_W{1'b0}}, in_pay[PAY_W-1 -: DCB]};
    assign cy_ext = {{BY_W{1'b0}}, in_pay[PAY_W-DCB-1 -: DCB]};

    // Per axis: inside the last cell only on its far edge, with full far weight.
    always_comb
    begin
        inx  = 1'b0;
        bx_c = '0;
        fx_c = '0;
        if (SIZE_W'(ipx) < width - 1'b1)
        begin
            inx  = 1'b1;
            bx_c = BX_W'(ipx);
            fx_c = {1'b0, frx};
        end
        else if ((SIZE_W'(ipx) == width - 1'b1) && (frx == '0))
        begin
            inx  = 1'b1;
            bx_c = BX_W'(width - SIZE_W'(MIN_SIZE));
            fx_c = ONE_W;
        end
        iny  = 1'b0;
        by_c = '0;
        fy_c = '0;
        if (SIZE_W'(ipy) < height - 1'b1)
        begin
            iny  = 1'b1;
            by_c = BY_W'(ipy);
            fy_c = {1'b0, fry};
        end
        else if ((SIZE_W'(ipy) == height - 1'b1) && (fry == '0))
        begin
            iny  = 1'b1;
            by_c = BY_W'(height - SIZE_W'(MIN_SIZE));
            fy_c = ONE_W;
        end
    end

    // Four banks by row and column parity: the four neighbors hit one bank each.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        localparam int PY = b / 2;
        localparam int PX = b % 2;
        logic [BY_W:0]   rrow;
        logic [BX_W:0]   rcol;
        logic [AW-1:0]   raddr, waddr;
        logic            we;

        assign rrow  = {1'b0, by1_reg} + ((by1_reg[0] == 1'(PY)) ? '0 : (BY_W+1)'(1));
        assign rcol  = {1'b0, bx1_reg} + ((bx1_reg[0] == 1'(PX)) ? '0 : (BX_W+1)'(1));
        assign raddr = AW'(32'(rrow >> 1) * WB + 32'(rcol >> 1));
        assign waddr = AW'(32'(wrow1_reg >> 1) * WB + 32'(wcol1_reg >> 1));
        assign we    = ctl1_reg.valid && (ctl1_reg.kind == KIND_WRITE)
                       && (wrow1_reg[0] == 1'(PY)) && (wcol1_reg[0] == 1'(PX));

        pbw_ram #(
            .WIDTH (PIX_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wpix1_reg),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

    assign nxw = ONE_W - fx1_reg;
    assign nyw = ONE_W - fy1_reg;

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            p_c[k][0] = rdata[{by0_reg, bx0_reg}][k*CH_W +: CH_W];
            p_c[k][1] = rdata[{by0_reg, !bx0_reg}][k*CH_W +: CH_W];
            p_c[k][2] = rdata[{!by0_reg, bx0_reg}][k*CH_W +: CH_W];
            p_c[k][3] = rdata[{!by0_reg, !bx0_reg}][k*CH_W +: CH_W];
            acc[k] = prod_reg[k][0] + prod_reg[k][1] + prod_reg[k][2] + prod_reg[k][3];
            pix_c[k*CH_W +: CH_W] = acc[k][2*FRAC +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= ctl3_reg.valid && (ctl3_reg.kind == KIND_REQUEST);
        end
    end

    always_ff @(posedge clk)
    begin
        in1_reg   <= in_ok && inx && iny;
        bx1_reg   <= bx_c;
        by1_reg   <= by_c;
        fx1_reg   <= fx_c;
        fy1_reg   <= fy_c;
        wcol1_reg <= cx_ext[BX_W-1:0];
        wrow1_reg <= cy_ext[BY_W-1:0];
        wpix1_reg <= in_pay[PIX_W-1:0];

        in2_reg <= in1_reg;
        bx0_reg <= bx1_reg[0];
        by0_reg <= by1_reg[0];
        w00_reg <= nyw * nxw;
        w01_reg <= nyw * fx1_reg;
        w10_reg <= fy1_reg * nxw;
        w11_reg <= fy1_reg * fx1_reg;

        in3_reg <= in2_reg;
        for (int k = 0; k < CHANNELS; k++)
        begin
            prod_reg[k][0] <= p_c[k][0] * w00_reg;
            prod_reg[k][1] <= p_c[k][1] * w01_reg;
            prod_reg[k][2] <= p_c[k][2] * w10_reg;
            prod_reg[k][3] <= p_c[k][3] * w11_reg;
        end

        inside_reg <= in3_reg;
        pix_reg    <= in3_reg ? pix_c : '0;
    end

    assign done       = done_reg;
    assign pixel_out  = pix_reg;
    assign inside_res = inside_reg;

endmodule

>>> rtl/core/perspective_bilinear_warp_top.sv
// Perspective warp with bilinear sampling.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. kind 0 stores pixel_in at (coord_x, coord_y) of the source image;
// writes beyond the store are dropped. kind 1 asks for the warped pixel at
// destination (coord_x, coord_y).
// Result channel: each request yields one item on pixel_out / inside_res,
// marked by done for exactly one cycle. Writes yield nothing.
// Division: the restoring divider yields one quotient bit per stage, for
// QB = 16 + clog2(max(SRC_MAX_WIDTH, SRC_MAX_HEIGHT)) bits (25 at defaults).
// Throughput: one item per cycle, writes and requests mixed in any order.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
// Configuration: write wr_data to register wr_index with wr_en, only while
// idle. Reset loads the identity matrix and a 512 x 512 source; the image
// store holds nothing defined until written.
module perspective_bilinear_warp_top #(
    parameter int SRC_MAX_WIDTH  = pbw_pkg::DEF_SRC_MAX_WIDTH,
    parameter int SRC_MAX_HEIGHT = pbw_pkg::DEF_SRC_MAX_HEIGHT,
    parameter int CHANNELS       = pbw_pkg::DEF_CHANNELS,
    parameter int DST_COORD_BITS = pbw_pkg::DEF_DST_COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [DST_COORD_BITS-1:0]            coord_x,
    input  logic [DST_COORD_BITS-1:0]            coord_y,
    input  logic [pbw_pkg::CH_W*CHANNELS-1:0]    pixel_in,
    input  logic                                 wr_en,
    input  logic [pbw_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [pbw_pkg::CFG_DATA_W-1:0]       wr_data,
    output logic                                 done,
    output logic [pbw_pkg::CH_W*CHANNELS-1:0]    pixel_out,
    output logic                                 inside_res
);
    import pbw_pkg::*;

    localparam int PIX_W   = CH_W * CHANNELS;
    localparam int ENTRY_W = 2 * DST_COORD_BITS + PIX_W + 1;
    localparam int PAY_W   = ENTRY_W - 1;
    localparam int QB      = quot_bits(SRC_MAX_WIDTH, SRC_MAX_HEIGHT);

    // Register file; resets to the identity mapping.
    logic [CFG_DATA_W-1:0] row_x_reg, row_y_reg, row_w_reg, offsets_reg;
    logic [COEF_W-1:0]     w_offset_reg;
    logic [SIZE_CFG_W-1:0] width_reg, height_reg;
    coef_t                 coef;

    logic                  full, push;
    logic [ENTRY_W-1:0]    entry;
    logic                  q_valid;
    logic [ENTRY_W-1:0]    q_data;

    ctl_t                  map_ctl;
    logic                  map_ok;
    logic [QB-1:0]         map_qx, map_qy;
    logic [PAY_W-1:0]      map_pay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= 64'h0000_0000_0100_0000;
            row_y_reg    <= 64'h0100_0000_0000_0000;
            row_w_reg    <= '0;
            offsets_reg  <= '0;
            w_offset_reg <= 32'h0100_0000;
            width_reg    <= 10'd512;
            height_reg   <= 10'd512;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_ROW_X:      row_x_reg    <= wr_data;
                REG_ROW_Y:      row_y_reg    <= wr_data;
                REG_ROW_W:      row_w_reg    <= wr_data;
                REG_OFFSETS:    offsets_reg  <= wr_data;
                REG_W_OFFSET:   w_offset_reg <= wr_data[COEF_W-1:0];
                REG_SRC_WIDTH:  width_reg    <= wr_data[SIZE_CFG_W-1:0];
                REG_SRC_HEIGHT: height_reg   <= wr_data[SIZE_CFG_W-1:0];
                default:        ; // drop writes to unknown indexes
            endcase
        end
    end

    // Unpack the coefficients and clamp the image size to the store.
    always_comb
    begin
        coef.h00    = row_x_reg[COEF_W-1:0];
        coef.h01    = row_x_reg[CFG_DATA_W-1:COEF_W];
        coef.h10    = row_y_reg[COEF_W-1:0];
        coef.h11    = row_y_reg[CFG_DATA_W-1:COEF_W];
        coef.h20    = row_w_reg[COEF_W-1:0];
        coef.h21    = row_w_reg[CFG_DATA_W-1:COEF_W];
        coef.h02    = offsets_reg[COEF_W-1:0];
        coef.h12    = offsets_reg[CFG_DATA_W-1:COEF_W];
        coef.h22    = w_offset_reg;
        coef.width  = clamp_size(width_reg, SIZE_W'(SRC_MAX_WIDTH));
        coef.height = clamp_size(height_reg, SIZE_W'(SRC_MAX_HEIGHT));
    end

    // Front end: take items, drop stray writes, queue the rest.
    pbw_front #(
        .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
        .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
        .CHANNELS       (CHANNELS),
        .DST_COORD_BITS (DST_COORD_BITS)
    ) u_front (
        .start    (start),
        .kind     (kind),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .pixel_in (pixel_in),
        .full     (full),
        .busy     (busy),
        .push     (push),
        .entry    (entry)
    );

    pbw_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // Back end, part one: projection and the pipelined divide.
    pbw_map #(
        .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
        .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
        .CHANNELS       (CHANNELS),
        .DST_COORD_BITS (DST_COORD_BITS)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_data  (q_data),
        .coef     (coef),
        .out_ctl  (map_ctl),
        .out_ok   (map_ok),
        .out_qx   (map_qx),
        .out_qy   (map_qy),
        .out_pay  (map_pay)
    );

    // Back end, part two: image store and bilinear mix. Writes reach the
    // store at the same stage as reads, which keeps item order.
    pbw_sample #(
        .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
        .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
        .CHANNELS       (CHANNELS),
        .DST_COORD_BITS (DST_COORD_BITS)
    ) u_sample (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (map_ctl),
        .in_ok      (map_ok),
        .in_qx      (map_qx),
        .in_qy      (map_qy),
        .in_pay     (map_pay),
        .width      (coef.width),
        .height     (coef.height),
        .done       (done),
        .pixel_out  (pixel_out),
        .inside_res (inside_res)
    );

endmodule
